// ----- hdl/wlf_pkg.sv -----
// Shared types, constants and saturating helpers for the weighted line fit block.
`timescale 1ns / 1ps
package wlf_pkg;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_WGT, ST_PASS, ST_ACC,
    ST_A_XY, ST_A_XYW, ST_A_XW, ST_A_XX, ST_A_XXW, ST_A_YW,
    ST_DET1, ST_DET2, ST_DETCHK, ST_NUM1, ST_NUM2, ST_SLOPE, ST_TIME,
    ST_Q1, ST_TP, ST_Q2, ST_ECST, ST_ECOV, ST_ELIN, ST_USED,
    ST_RES, ST_R_C, ST_R_P, ST_R_XX, ST_R_XXE, ST_R_SQ, ST_R_DEV,
    ST_R_DD, ST_R_DDW, ST_PEND, ST_OUT
  } fit_state_e;

  localparam logic [0:0] CFG_TIME_MODE = 1'd0;
  localparam logic [0:0] CFG_ALLOWED   = 1'd1;

  localparam logic [6:0] MUL_LAST  = 7'd3;
  localparam logic [6:0] DIV_LAST  = 7'd95;
  localparam logic [6:0] SQRT_LAST = 7'd31;

  localparam logic [63:0] SMAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q     = 64'h0000_0001_0000_0000;
  localparam logic [63:0] LIGHT_Q   = 64'd1287588246;
  localparam logic [63:0] TOL_Q     = 64'd14173392077;
  localparam logic [63:0] INV_MAG   = 64'((128'h1 << 64) / 128'd1287588246);
  localparam logic [63:0] INV_LIGHT = 64'(-INV_MAG);
  localparam logic [63:0] UNSET_Q   = 64'(64'd1000 << 32);
  localparam logic [63:0] BAD_Q     = 64'(-(64'd999 << 32));
  localparam logic [63:0] WGT_NUM   = 64'd65536;
  localparam logic [31:0] ERR_INIT  = 32'(32'd1000 << 16);
  localparam logic signed [31:0] NOHIT_RAW = -32'sd3276800;
  localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? 64'(-a) : a;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic signed [64:0] s;
    logic signed [64:0] hi;
    s  = $signed({a[63], a}) + $signed({b[63], b});
    hi = $signed({1'b0, SMAX});
    if (s > hi) return SMAX;
    else if (s < -hi) return 64'(-SMAX);
    else return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic signed [64:0] s;
    logic signed [64:0] hi;
    s  = $signed({a[63], a}) - $signed({b[63], b});
    hi = $signed({1'b0, SMAX});
    if (s > hi) return SMAX;
    else if (s < -hi) return 64'(-SMAX);
    else return s[63:0];
  endfunction

  // Q32.32 to Q16.16, truncate toward zero, saturate symmetric
  function automatic logic [31:0] out16(input logic [63:0] v);
    logic [63:0] m;
    logic [31:0] r;
    m = mag64(v) >> 16;
    r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    return v[63] ? 32'(-r) : r;
  endfunction

endpackage

// ----- hdl/weighted_line_fit_outlier_reject.sv -----
// Top level: layer store, fit sequencer with outlier rejection, result stream.
// A non-final word is stored and the input stays ready. A final word starts the fit:
//   a weight for each of the n loaded layers, then per pass an accumulation over the
//   fitted hits, the solve and a residual sweep over the layers; then n result words,
//   one per cycle while m_axis_tready is high. Throughput is set by the single shared
//   multiply/divide/sqrt unit; no word is taken while fitting.
// Reset: async active low; clears layer count, window, control state and
//   registers time_mode to 0, allowed_deviation to 1.0.
`timescale 1ns / 1ps
module weighted_line_fit_outlier_reject #(
  parameter int LAYERS     = 12,
  parameter int MAX_PASSES = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // x_pos[31:0] y_meas[63:32] y_variance[95:64] hit_enabled[96] window_first[101:97]
  // window_last[106:102] skip_layer_a[112:107] skip_layer_b[118:113]
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // expected[31:0] deviation[63:32] expected_error[95:64] fit_failed[96]
  // intercept[128:97] slope[160:129] intercept_var[192:161] slope_var[224:193]
  // covariance[256:225] chi_square[296:257] hits_used[302:297]
  output logic [303:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import wlf_pkg::*;

  localparam int IW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int CW = $clog2(LAYERS + 1);
  localparam int PW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

  fit_state_e state_q, state_d;

  logic          time_mode_q;
  logic [31:0]   allowed_q;
  logic [4:0]    win_first_q, win_last_q;
  logic [5:0]    skip_a_q, skip_b_q;
  logic [CW-1:0] count_q, n_q, idx_q;
  logic [PW-1:0] pass_q;
  logic [5:0]    used_q;
  logic          failed_q;
  logic          issued_q;

  logic [31:0] lx [LAYERS];
  logic [31:0] ly [LAYERS];
  logic [31:0] lv [LAYERS];
  logic [1:0]  lf [LAYERS];
  logic [48:0] wq [LAYERS];
  logic        live [LAYERS];
  logic [63:0] yexp [LAYERS];
  logic [31:0] yerr [LAYERS];
  logic [63:0] ydev [LAYERS];

  logic [63:0] sxxy_q, sx_q, sxx_q, sy_q, sn_q, det_q;
  logic [63:0] slope_q, tmp_q, icpt_q, ecst_q, ecov_q, elin_q, chi_q;
  logic [63:0] t_q, u_q, c_q, ye_q, dv_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     op_req;
  logic     alu_done;
  logic [63:0] alu_res;

  logic          in_acc, out_acc, store_en;
  logic [IW-1:0] ri, wi;
  logic [CW-1:0] count_new;
  logic          idx_end, idx_last;
  logic [5:0]    idx6;
  logic          inwin, en_c, live_c, fit_ok;
  logic [63:0]   xq_c, yq_c, wq_c, dev_c;
  logic [31:0]   var_nz;
  logic          dev_big;
  logic [39:0]   chi40;

  wlf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign alu_done      = alu_rsp.done;
  assign alu_res       = alu_rsp.res;
  assign alu_req.start = op_req && !issued_q;

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = state_q == ST_OUT;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign store_en      = count_q < CW'(LAYERS);
  assign count_new     = store_en ? CW'(count_q + 1'b1) : count_q;
  assign wi            = count_q[IW-1:0];
  assign ri            = idx_q[IW-1:0];
  assign idx_end       = idx_q == n_q;
  assign idx_last      = CW'(idx_q + 1'b1) == n_q;
  assign idx6          = 6'(idx_q);

  assign inwin  = (idx6 >= {1'b0, win_first_q}) && (idx6 <= {1'b0, win_last_q}) &&
                  (idx6 != skip_a_q) && (idx6 != skip_b_q);
  assign en_c   = lf[ri][0];
  assign live_c = live[ri];
  assign fit_ok = inwin && live_c && en_c;

  assign xq_c   = {{16{lx[ri][31]}}, lx[ri], 16'h0};
  assign yq_c   = {{16{ly[ri][31]}}, ly[ri], 16'h0};
  assign wq_c   = {15'h0, wq[ri]};
  assign var_nz = (lv[ri] == 32'h0) ? 32'd1 : lv[ri];
  assign dev_c  = sat_sub(yq_c, ye_q);
  assign dev_big = mag64(dev_c) > {16'h0, allowed_q, 16'h0};

  // sequencer: each arithmetic state issues one operation and advances on done
  always_comb begin
    state_d     = state_q;
    op_req      = 1'b0;
    alu_req.op  = ALU_MUL;
    alu_req.a   = '0;
    alu_req.b   = '0;
    unique case (state_q)
      ST_IDLE: if (in_acc && s_axis_tlast) state_d = ST_WGT;
      ST_WGT: begin
        if (idx_end) state_d = ST_PASS;
        else begin
          op_req = 1'b1; alu_req.op = ALU_DIV;
          alu_req.a = WGT_NUM; alu_req.b = {32'h0, var_nz};
        end
      end
      ST_PASS: state_d = ST_ACC;
      ST_ACC: begin
        if (idx_end) state_d = ST_DET1;
        else if (fit_ok) state_d = ST_A_XY;
      end
      ST_A_XY: begin
        op_req = 1'b1; alu_req.a = xq_c; alu_req.b = yq_c;
        if (alu_done) state_d = ST_A_XYW;
      end
      ST_A_XYW: begin
        op_req = 1'b1; alu_req.a = t_q; alu_req.b = wq_c;
        if (alu_done) state_d = ST_A_XW;
      end
      ST_A_XW: begin
        op_req = 1'b1; alu_req.a = xq_c; alu_req.b = wq_c;
        if (alu_done) state_d = ST_A_XX;
      end
      ST_A_XX: begin
        op_req = 1'b1; alu_req.a = xq_c; alu_req.b = xq_c;
        if (alu_done) state_d = ST_A_XXW;
      end
      ST_A_XXW: begin
        op_req = 1'b1; alu_req.a = t_q; alu_req.b = wq_c;
        if (alu_done) state_d = ST_A_YW;
      end
      ST_A_YW: begin
        op_req = 1'b1; alu_req.a = yq_c; alu_req.b = wq_c;
        if (alu_done) state_d = ST_ACC;
      end
      ST_DET1: begin
        op_req = 1'b1; alu_req.a = sxx_q; alu_req.b = sn_q;
        if (alu_done) state_d = ST_DET2;
      end
      ST_DET2: begin
        op_req = 1'b1; alu_req.a = sx_q; alu_req.b = sx_q;
        if (alu_done) state_d = ST_DETCHK;
      end
      ST_DETCHK: begin
        if (!sn_q[63] && sn_q != 64'h0 && det_q != 64'h0) state_d = ST_NUM1;
        else state_d = ST_OUT;
      end
      ST_NUM1: begin
        op_req = 1'b1; alu_req.a = sxxy_q; alu_req.b = sn_q;
        if (alu_done) state_d = ST_NUM2;
      end
      ST_NUM2: begin
        op_req = 1'b1; alu_req.a = sx_q; alu_req.b = sy_q;
        if (alu_done) state_d = ST_SLOPE;
      end
      ST_SLOPE: begin
        op_req = 1'b1; alu_req.op = ALU_DIV; alu_req.a = t_q; alu_req.b = det_q;
        if (alu_done) state_d = time_mode_q ? ST_TIME : ST_Q1;
      end
      ST_TIME: begin
        op_req = 1'b1; alu_req.a = LIGHT_Q; alu_req.b = slope_q;
        if (alu_done) state_d = ST_Q1;
      end
      ST_Q1: begin
        op_req = 1'b1; alu_req.op = ALU_DIV; alu_req.a = sy_q; alu_req.b = sn_q;
        if (alu_done) state_d = ST_TP;
      end
      ST_TP: begin
        op_req = 1'b1; alu_req.a = tmp_q; alu_req.b = sx_q;
        if (alu_done) state_d = ST_Q2;
      end
      ST_Q2: begin
        op_req = 1'b1; alu_req.op = ALU_DIV; alu_req.a = t_q; alu_req.b = sn_q;
        if (alu_done) state_d = ST_ECST;
      end
      ST_ECST: begin
        op_req = 1'b1; alu_req.op = ALU_DIV; alu_req.a = sxx_q; alu_req.b = det_q;
        if (alu_done) state_d = ST_ECOV;
      end
      ST_ECOV: begin
        op_req = 1'b1; alu_req.op = ALU_DIV; alu_req.a = sx_q; alu_req.b = det_q;
        if (alu_done) state_d = ST_ELIN;
      end
      ST_ELIN: begin
        op_req = 1'b1; alu_req.op = ALU_DIV; alu_req.a = sn_q; alu_req.b = det_q;
        if (alu_done) state_d = ST_USED;
      end
      ST_USED: state_d = (used_q < 6'd3) ? ST_OUT : ST_RES;
      ST_RES: state_d = idx_end ? ST_PEND : ST_R_C;
      ST_R_C: begin
        op_req = 1'b1; alu_req.a = ecov_q; alu_req.b = xq_c;
        if (alu_done) state_d = ST_R_P;
      end
      ST_R_P: begin
        op_req = 1'b1; alu_req.a = tmp_q; alu_req.b = xq_c;
        if (alu_done) state_d = ST_R_XX;
      end
      ST_R_XX: begin
        op_req = 1'b1; alu_req.a = xq_c; alu_req.b = xq_c;
        if (alu_done) state_d = ST_R_XXE;
      end
      ST_R_XXE: begin
        op_req = 1'b1; alu_req.a = elin_q; alu_req.b = t_q;
        if (alu_done) state_d = ST_R_SQ;
      end
      ST_R_SQ: begin
        op_req = 1'b1; alu_req.op = ALU_SQRT; alu_req.a = mag64(t_q);
        if (alu_done) state_d = ST_R_DEV;
      end
      ST_R_DEV: state_d = (live_c && en_c && inwin) ? ST_R_DD : ST_RES;
      ST_R_DD: begin
        op_req = 1'b1; alu_req.a = dv_q; alu_req.b = dv_q;
        if (alu_done) state_d = ST_R_DDW;
      end
      ST_R_DDW: begin
        op_req = 1'b1; alu_req.a = t_q; alu_req.b = wq_c;
        if (alu_done) state_d = ST_RES;
      end
      ST_PEND: begin
        if (!failed_q || pass_q == PW'(MAX_PASSES - 1)) state_d = ST_OUT;
        else state_d = ST_PASS;
      end
      ST_OUT: if (out_acc && idx_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_mode_q <= 1'b0;
      allowed_q   <= 32'd65536;
      win_first_q <= '0;
      win_last_q  <= '0;
      skip_a_q    <= '0;
      skip_b_q    <= '0;
      count_q     <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      pass_q      <= '0;
      used_q      <= '0;
      failed_q    <= 1'b0;
      issued_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (alu_req.start) issued_q <= 1'b1;
      else if (alu_done) issued_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIME_MODE: time_mode_q <= cfg_wdata_i[0];
          default:       allowed_q   <= cfg_wdata_i;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (count_q == '0) begin
              win_first_q <= s_axis_tdata[101:97];
              win_last_q  <= s_axis_tdata[106:102];
              skip_a_q    <= s_axis_tdata[112:107];
              skip_b_q    <= s_axis_tdata[118:113];
            end
            if (s_axis_tlast) begin
              count_q  <= '0;
              n_q      <= count_new;
              idx_q    <= '0;
              pass_q   <= '0;
              used_q   <= '0;
              failed_q <= 1'b0;
            end else begin
              count_q <= count_new;
            end
          end
        end
        ST_WGT: if (alu_done) idx_q <= CW'(idx_q + 1'b1);
        ST_PASS: begin
          idx_q  <= '0;
          used_q <= '0;
        end
        ST_ACC: if (!idx_end && !fit_ok) idx_q <= CW'(idx_q + 1'b1);
        ST_A_YW: begin
          if (alu_done) begin
            used_q <= used_q + 6'd1;
            idx_q  <= CW'(idx_q + 1'b1);
          end
        end
        ST_DETCHK: begin
          if (!(!sn_q[63] && sn_q != 64'h0 && det_q != 64'h0)) begin
            failed_q <= 1'b1;
            idx_q    <= '0;
          end
        end
        ST_TIME: begin
          if (alu_done && !(mag64(sat_add(alu_res, ONE_Q)) < TOL_Q)) begin
            used_q   <= '0;
            failed_q <= 1'b1;
          end
        end
        ST_USED: begin
          idx_q <= '0;
          if (used_q >= 6'd3) failed_q <= 1'b0;
        end
        ST_R_DEV: begin
          if (live_c && en_c && inwin) begin
            if (dev_big) failed_q <= 1'b1;
          end else begin
            idx_q <= CW'(idx_q + 1'b1);
          end
        end
        ST_R_DDW: if (alu_done) idx_q <= CW'(idx_q + 1'b1);
        ST_PEND: begin
          idx_q <= '0;
          if (failed_q && pass_q != PW'(MAX_PASSES - 1)) pass_q <= PW'(pass_q + 1'b1);
        end
        ST_OUT: if (out_acc) idx_q <= CW'(idx_q + 1'b1);
        default: ;
      endcase
    end
  end

  // payload: layer store, per-layer fit data and fit accumulators
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && store_en) begin
      lx[wi] <= s_axis_tdata[31:0];
      ly[wi] <= s_axis_tdata[63:32];
      lv[wi] <= s_axis_tdata[95:64];
      lf[wi] <= {$signed(s_axis_tdata[63:32]) > NOHIT_RAW, s_axis_tdata[96]};
    end
    unique case (state_q)
      ST_WGT: begin
        if (alu_done) begin
          wq[ri]   <= alu_res[48:0];
          live[ri] <= lf[ri][1];
          yexp[ri] <= UNSET_Q;
          yerr[ri] <= ERR_INIT;
        end
      end
      ST_PASS: begin
        sxxy_q <= '0; sx_q <= '0; sxx_q <= '0; sy_q <= '0; sn_q <= '0;
        chi_q  <= '0;
      end
      ST_ACC: if (!idx_end) ydev[ri] <= UNSET_Q;
      ST_A_XY:  if (alu_done) t_q <= alu_res;
      ST_A_XYW: if (alu_done) sxxy_q <= sat_add(sxxy_q, alu_res);
      ST_A_XW:  if (alu_done) sx_q <= sat_add(sx_q, alu_res);
      ST_A_XX:  if (alu_done) t_q <= alu_res;
      ST_A_XXW: if (alu_done) sxx_q <= sat_add(sxx_q, alu_res);
      ST_A_YW: begin
        if (alu_done) begin
          sy_q <= sat_add(sy_q, alu_res);
          sn_q <= sat_add(sn_q, wq_c);
        end
      end
      ST_DET1: if (alu_done) u_q <= alu_res;
      ST_DET2: if (alu_done) det_q <= sat_sub(u_q, alu_res);
      ST_DETCHK: begin
        if (!(!sn_q[63] && sn_q != 64'h0 && det_q != 64'h0)) begin
          slope_q <= BAD_Q; icpt_q <= BAD_Q; ecst_q <= BAD_Q;
          ecov_q  <= BAD_Q; elin_q <= BAD_Q;
        end
      end
      ST_NUM1: if (alu_done) u_q <= alu_res;
      ST_NUM2: if (alu_done) t_q <= sat_sub(u_q, alu_res);
      ST_SLOPE: begin
        if (alu_done) begin
          slope_q <= alu_res;
          tmp_q   <= alu_res;
        end
      end
      ST_TIME: begin
        // pin the working slope tmp_q when it lies near minus the inverse light speed
        if (alu_done && mag64(sat_add(alu_res, ONE_Q)) < TOL_Q) tmp_q <= INV_LIGHT;
      end
      ST_Q1:   if (alu_done) u_q <= alu_res;
      ST_TP:   if (alu_done) t_q <= alu_res;
      ST_Q2:   if (alu_done) icpt_q <= sat_sub(u_q, alu_res);
      ST_ECST: if (alu_done) ecst_q <= alu_res;
      ST_ECOV: if (alu_done) ecov_q <= 64'(-alu_res);
      ST_ELIN: if (alu_done) elin_q <= alu_res;
      ST_R_C:  if (alu_done) c_q <= alu_res;
      ST_R_P: begin
        if (alu_done) begin
          ye_q     <= sat_add(alu_res, icpt_q);
          yexp[ri] <= sat_add(alu_res, icpt_q);
        end
      end
      ST_R_XX:  if (alu_done) t_q <= alu_res;
      ST_R_XXE: if (alu_done) t_q <= sat_add(sat_add(ecst_q, sat_add(c_q, c_q)), alu_res);
      ST_R_SQ:  if (alu_done) yerr[ri] <= alu_res[31:0];
      ST_R_DEV: begin
        if (live_c) begin
          ydev[ri] <= dev_c;
          dv_q     <= dev_c;
          if (en_c && inwin && dev_big) live[ri] <= 1'b0;
        end
      end
      ST_R_DD:  if (alu_done) t_q <= alu_res;
      ST_R_DDW: if (alu_done) chi_q <= sat_add(chi_q, alu_res);
      default: ;
    endcase
  end

  assign chi40 = (|chi_q[63:56]) ? 40'hFF_FFFF_FFFF : chi_q[55:16];

  assign m_axis_tdata = {1'b0, used_q, chi40, out16(ecov_q), out16(elin_q), out16(ecst_q),
                         out16(slope_q), out16(icpt_q), failed_q, yerr[ri],
                         out16(ydev[ri]), out16(yexp[ri])};
  assign m_axis_tlast = idx_last;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input and output open together");
  a_out_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (idx_q < n_q)) else $error("result index past loaded layers");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LAYERS)) else $error("layer count overflow");
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> issued_q) else $error("alu result without request");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (6'(n_q) >= used_q)) else $error("more hits than layers");
`endif

endmodule

// ----- hdl/wlf_alu.sv -----
// Shared iterative unit: Q32.32 multiply, Q32.32 divide and integer square root.
`timescale 1ns / 1ps
module wlf_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wlf_pkg::alu_req_t req_i,
  output wlf_pkg::alu_rsp_t rsp_o
);
  import wlf_pkg::*;

  logic          busy_q, done_q;
  alu_op_e       op_q;
  logic [6:0]    cnt_q;
  logic          neg_q, zero_q, anz_q;
  logic [63:0]   ma_q, mb_q;
  logic [127:0]  acc_q;
  logic [95:0]   num_q;
  logic [63:0]   rem_q;
  logic [63:0]   sv_q, sres_q, sbit_q;

  logic          take;
  logic [6:0]    last_cnt;
  logic [31:0]   pa, pb;
  logic [63:0]   prod;
  logic [127:0]  add_v;
  logic [64:0]   remsh;
  logic          qbit;
  logic [63:0]   rem_next;
  logic [63:0]   trial;
  logic [63:0]   m_res;

  assign take = req_i.start && !busy_q;

  always_comb begin
    unique case (op_q)
      ALU_MUL:  last_cnt = MUL_LAST;
      ALU_DIV:  last_cnt = DIV_LAST;
      default:  last_cnt = SQRT_LAST;
    endcase
  end

  // one 32x32 partial product per cycle
  assign pa   = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign pb   = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign prod = 64'(pa) * 64'(pb);
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    add_v = {64'h0, prod};
      2'd3:    add_v = {prod, 64'h0};
      default: add_v = {32'h0, prod, 32'h0};
    endcase
  end

  assign remsh    = {rem_q, num_q[95]};
  assign qbit     = remsh >= {1'b0, mb_q};
  assign rem_next = qbit ? 64'(remsh - {1'b0, mb_q}) : remsh[63:0];

  assign trial = sres_q + sbit_q;

  always_comb begin
    unique case (op_q)
      ALU_MUL: m_res = (|acc_q[127:95]) ? SMAX : acc_q[95:32];
      ALU_DIV: begin
        if (zero_q) m_res = anz_q ? SMAX : 64'h0;
        else m_res = (|num_q[95:63]) ? SMAX : {1'b0, num_q[62:0]};
      end
      default: m_res = {32'h0, sres_q[31:0]};
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? 64'(-m_res) : m_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else begin
      done_q <= 1'b0;
      if (take) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        if (cnt_q == last_cnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ma_q   <= mag64(req_i.a);
      mb_q   <= mag64(req_i.b);
      acc_q  <= '0;
      num_q  <= {mag64(req_i.a), 32'h0};
      rem_q  <= '0;
      sv_q   <= req_i.a;
      sres_q <= '0;
      sbit_q <= SQRT_BIT0;
      zero_q <= req_i.b == 64'h0;
      anz_q  <= req_i.a != 64'h0;
      unique case (req_i.op)
        ALU_MUL: neg_q <= req_i.a[63] ^ req_i.b[63];
        ALU_DIV: neg_q <= (req_i.b == 64'h0) ? req_i.a[63] : (req_i.a[63] ^ req_i.b[63]);
        default: neg_q <= 1'b0;
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        ALU_MUL: acc_q <= acc_q + add_v;
        ALU_DIV: begin
          rem_q <= rem_next;
          num_q <= {num_q[94:0], qbit};
        end
        default: begin
          if (sv_q >= trial) begin
            sv_q   <= sv_q - trial;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("alu done held");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q) else $error("alu done while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q)) else $error("alu done without work");
`endif

endmodule

// ----- dv/tb_weighted_line_fit_outlier_reject.sv -----
// Testbench for weighted_line_fit_outlier_reject: layer tracks in, per-layer fit words checked.
`timescale 1ns / 1ps
module tb_weighted_line_fit_outlier_reject;
  import wlf_pkg::*;

  localparam int  NL         = 12;
  localparam int  NPASS      = 6;
  localparam int  CYCLE_CAP  = 3000000;
  localparam logic [63:0] QMAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QONE   = 64'h1_0000_0000;
  localparam logic [63:0] QLIGHT = 64'd1287588246;
  localparam logic [63:0] QTOL   = 64'd14173392077;
  localparam logic signed [31:0] NO_HIT = -32'sd3276800;

  typedef struct packed {
    logic [5:0]  skip_b;
    logic [5:0]  skip_a;
    logic [4:0]  win_last;
    logic [4:0]  win_first;
    logic        hit_en;
    logic [31:0] variance;
    logic [31:0] y;
    logic [31:0] x;
  } layer_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [0:0]   cfg_idx_i;
  logic [31:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // x_pos, y_meas, y_variance, hit_enabled, window_first, window_last, skip_layer_a,
  // skip_layer_b
  logic [119:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // expected, deviation, expected_error, fit_failed, intercept, slope, intercept_var,
  // slope_var, covariance, chi_square, hits_used
  logic [303:0] m_axis_tdata;
  logic         m_axis_tlast;

  weighted_line_fit_outlier_reject u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #6 clk_i = ~clk_i;

  // fit model state
  logic [31:0] st_x[NL], st_y[NL], st_var[NL];
  bit          st_en[NL];
  int          st_count;
  logic [4:0]  st_first, st_last;
  logic [5:0]  st_skip_a, st_skip_b;
  bit          time_mode;
  logic [31:0] allowed_dev;

  logic [304:0] fit_words[$];
  int  fail_count;
  int  cycles;
  bit  tx_quiet, rx_quiet;
  bit  rx_hold_req;

  // ---------------- Q32.32 arithmetic ----------------
  function automatic logic [63:0] q_mag(input logic [63:0] a);
    return a[63] ? 64'(-a) : a;
  endfunction

  function automatic logic [63:0] q_signed(input logic [63:0] m, input bit neg);
    if (m > QMAX) m = QMAX;
    return neg ? 64'(-m) : m;
  endfunction

  function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({1'b0, QMAX})) return QMAX;
    if (s < -$signed({1'b0, QMAX})) return 64'(-QMAX);
    return s[63:0];
  endfunction

  function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
    return q_add(a, 64'(-b));
  endfunction

  function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, q_mag(a)} * {64'b0, q_mag(b)};
    return q_signed((p[127:95] != 0) ? QMAX : p[95:32], a[63] ^ b[63]);
  endfunction

  function automatic logic [63:0] q_div(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] q;
    if (b == 0) return q_signed((a != 0) ? QMAX : 64'd0, a[63]);
    q = {32'b0, q_mag(a), 32'b0} / {64'b0, q_mag(b)};
    return q_signed((q[127:63] != 0) ? QMAX : q[63:0], a[63] ^ b[63]);
  endfunction

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] to_q16(input logic [63:0] v);
    logic [63:0] m;
    logic [31:0] r;
    m = q_mag(v) >> 16;
    r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    return v[63] ? 32'(-r) : r;
  endfunction

  // ---------------- line fit prediction ----------------
  task automatic predict_fit(input int n);
    logic [63:0] xq[NL], yq[NL], wq[NL], yexp[NL], ydev[NL];
    logic [31:0] yerr[NL];
    bit          live[NL], inwin[NL];
    logic [63:0] allowed, inv_light, slope, icpt, ecst, ecov, elin, chi;
    logic [63:0] sxxy, sx, sxx, sy, sn, det, tmp, c, v;
    logic [31:0] variance;
    logic [39:0] c40;
    int          used;
    bit          failed;
    allowed   = {16'b0, allowed_dev, 16'b0};
    inv_light = 64'(-q_div(QONE, QLIGHT));
    slope = 64'(-(64'd999 << 32));
    icpt = slope; ecst = slope; ecov = slope; elin = slope;
    chi = 0; used = 0; failed = 0;
    for (int i = 0; i < n; i++) begin
      xq[i]    = {{16{st_x[i][31]}}, st_x[i], 16'b0};
      yq[i]    = {{16{st_y[i][31]}}, st_y[i], 16'b0};
      variance = (st_var[i] != 0) ? st_var[i] : 32'd1;
      wq[i]    = (64'd1 << 48) / variance;
      live[i]  = $signed(st_y[i]) > NO_HIT;
      inwin[i] = i >= st_first && i <= st_last && i != st_skip_a && i != st_skip_b;
      yexp[i]  = 64'd1000 << 32;
      yerr[i]  = 32'd1000 << 16;
    end
    for (int p = 0; p < NPASS; p++) begin
      sxxy = 0; sx = 0; sxx = 0; sy = 0; sn = 0;
      used = 0;
      chi  = 0;
      for (int i = 0; i < n; i++) begin
        ydev[i] = 64'd1000 << 32;
        if (inwin[i] && live[i] && st_en[i]) begin
          sxxy = q_add(sxxy, q_mul(q_mul(xq[i], yq[i]), wq[i]));
          sx   = q_add(sx, q_mul(xq[i], wq[i]));
          sxx  = q_add(sxx, q_mul(q_mul(xq[i], xq[i]), wq[i]));
          sy   = q_add(sy, q_mul(yq[i], wq[i]));
          sn   = q_add(sn, wq[i]);
          used++;
        end
      end
      det = q_sub(q_mul(sxx, sn), q_mul(sx, sx));
      if (!($signed(sn) > 0 && det != 0)) begin
        slope = 64'(-(64'd999 << 32));
        icpt = slope; ecst = slope; ecov = slope; elin = slope;
        failed = 1;
        break;
      end
      slope = q_div(q_sub(q_mul(sxxy, sn), q_mul(sx, sy)), det);
      tmp = slope;
      if (time_mode) begin
        if (q_mag(q_add(q_mul(QLIGHT, slope), QONE)) < QTOL) tmp = inv_light;
        else begin
          used   = 0;
          failed = 1;
        end
      end
      icpt = q_sub(q_div(sy, sn), q_div(q_mul(tmp, sx), sn));
      ecst = q_div(sxx, det);
      ecov = 64'(-q_div(sx, det));
      elin = q_div(sn, det);
      if (used < 3) break;
      failed = 0;
      for (int i = 0; i < n; i++) begin
        c       = q_mul(ecov, xq[i]);
        yexp[i] = q_add(q_mul(tmp, xq[i]), icpt);
        v       = q_add(q_add(ecst, q_add(c, c)), q_mul(elin, q_mul(xq[i], xq[i])));
        yerr[i] = floor_sqrt(q_mag(v));
        if (live[i]) begin
          ydev[i] = q_sub(yq[i], yexp[i]);
          if (st_en[i] && inwin[i]) begin
            // reject the hit for the next pass
            if (q_mag(ydev[i]) > allowed) begin
              live[i] = 0;
              failed  = 1;
            end
            chi = q_add(chi, q_mul(q_mul(ydev[i], ydev[i]), wq[i]));
          end
        end
      end
      if (!failed) break;
    end
    c40 = (chi[63:56] != 0) ? 40'hFF_FFFF_FFFF : chi[55:16];
    for (int i = 0; i < n; i++)
      fit_words.push_back({(i == n - 1), 1'b0, 6'(used), c40, to_q16(ecov), to_q16(elin),
                           to_q16(ecst), to_q16(slope), to_q16(icpt), failed, yerr[i],
                           to_q16(ydev[i]), to_q16(yexp[i])});
  endtask

  task automatic load_layer(input layer_word_t w, input bit final_layer);
    if (st_count == 0) begin
      st_first  = w.win_first;
      st_last   = w.win_last;
      st_skip_a = w.skip_a;
      st_skip_b = w.skip_b;
    end
    if (st_count < NL) begin
      st_x[st_count]   = w.x;
      st_y[st_count]   = w.y;
      st_var[st_count] = w.variance;
      st_en[st_count]  = w.hit_en;
      st_count++;
    end
    if (final_layer) begin
      predict_fit(st_count);
      st_count = 0;
    end
  endtask

  // ---------------- drivers ----------------
  task automatic send_layer(input layer_word_t w, input bit final_layer);
    if (!tx_quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, w};
    s_axis_tlast  <= final_layer;
    do @(posedge clk_i); while (!s_axis_tready);
    load_layer(w, final_layer);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (fit_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_TIME_MODE) time_mode = val[0];
    else allowed_dev = val;
  endtask

  function automatic layer_word_t track_layer(input int k, input longint a, input longint b,
                                              input logic [21:0] win);
    layer_word_t w;
    longint xv, yv;
    xv = k * 98304 + $urandom_range(0, 8191);
    yv = a + ((b * xv) >>> 16) + $signed(32'($urandom_range(0, 26214))) - 13107;
    w.variance = $urandom_range(655, 65536);
    w.hit_en   = ($urandom_range(0, 11) != 0);
    if ($urandom_range(0, 9) == 0)
      yv += ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(3, 10)) * 65536;
    if ($urandom_range(0, 19) == 0) yv = -3276800 - longint'($urandom_range(0, 1000000));
    w.x = 32'(xv);
    w.y = 32'(yv);
    {w.skip_b, w.skip_a, w.win_last, w.win_first} = win;
    // rare fully random word
    if ($urandom_range(0, 11) == 0) begin
      w.x = $urandom; w.y = $urandom; w.variance = $urandom;
      w.hit_en = $urandom_range(0, 1);
      {w.skip_b, w.skip_a, w.win_last, w.win_first} = 22'($urandom);
    end
    return w;
  endfunction

  task automatic send_track(input int n, input bit time_track);
    longint      a, b;
    logic [21:0] win;
    a = longint'($urandom_range(0, 40 * 65536)) - 20 * 65536;
    if (time_track) b = ($urandom_range(0, 5) == 0) ? 10 * 65536 : -218600 + 
                        longint'($urandom_range(0, 4000)) - 2000;
    else b = longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
    win[4:0]   = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 2));
    win[9:5]   = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(9, 31));
    win[15:10] = 6'($urandom);
    win[21:16] = ($urandom_range(0, 1)) ? 6'($urandom) : 6'd63;
    for (int k = 0; k < n; k++)
      send_layer(track_layer(k, a, b, win), k == n - 1);
  endtask

  function automatic int track_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(1, 11);
    if (r == 1) return $urandom_range(13, 15);
    return NL;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    layer_word_t w;
    // extremes of position, measurement and variance on a three-layer run
    w = '{skip_b: 6'd63, skip_a: 6'd63, win_last: 5'd31, win_first: 5'd0, hit_en: 1'b1,
          variance: 32'hFFFF_FFFF, y: 32'h7FFF_FFFF, x: 32'h7FFF_FFFF};
    send_layer(w, 1'b0);
    w.x = 32'h8000_0000; w.y = 32'h8000_0000 + 32'd3276800; w.variance = 32'd1;
    send_layer(w, 1'b0);
    w.x = 32'd0; w.y = 32'hFFFF_0000; w.variance = 32'd0;
    send_layer(w, 1'b1);
    // two hits only
    w = '{skip_b: 6'd63, skip_a: 6'd63, win_last: 5'd31, win_first: 5'd0, hit_en: 1'b1,
          variance: 32'd65536, y: 32'd65536, x: 32'd0};
    send_layer(w, 1'b0);
    w.x = 32'd65536; w.y = 32'd131072;
    send_layer(w, 1'b1);
    // single layer: degenerate
    send_layer(w, 1'b1);
    // overlong run with outlier, zero variance, disabled hit, no-hit layers, skips
    for (int k = 0; k < 14; k++) begin
      w.x = 32'(k * 65536);
      w.y = 32'(2 * 65536 + k * 32768);
      w.variance = 32'd6554;
      w.hit_en = 1'b1;
      if (k == 0) begin
        w.win_first = 5'd1; w.win_last = 5'd10; w.skip_a = 6'd4; w.skip_b = 6'd40;
      end else begin
        {w.skip_b, w.skip_a, w.win_last, w.win_first} = 22'($urandom);
      end
      if (k == 3) w.y = w.y + 32'(8 * 65536);
      if (k == 5) w.variance = 32'd0;
      if (k == 6) w.hit_en = 1'b0;
      if (k == 7) w.y = 32'(-3276800);
      if (k == 8) w.y = 32'(-60 * 65536);
      send_layer(w, k == 13);
    end
  endtask

  task automatic test_register_sweep();
    write_reg(CFG_TIME_MODE, 32'd1);
    repeat (3) send_track(track_len(), 1'b1);
    write_reg(CFG_TIME_MODE, 32'd0);
    write_reg(CFG_ALLOWED, 32'd0);
    repeat (2) send_track(track_len(), 1'b0);
    write_reg(CFG_ALLOWED, 32'hFFFF_FFFF);
    repeat (2) send_track(track_len(), 1'b0);
    write_reg(CFG_TIME_MODE, 32'd1);
    write_reg(CFG_ALLOWED, $urandom_range(16384, 196608));
    repeat (2) send_track(track_len(), 1'b1);
    write_reg(CFG_TIME_MODE, 32'd0);
    write_reg(CFG_ALLOWED, 32'd65536);
  endtask

  task automatic test_random_tracks();
    repeat (7) send_track(track_len(), 1'b0);
  endtask

  task automatic test_output_stall();
    rx_hold_req = 1'b1;
    repeat (2) send_track(NL, 1'b0);
  endtask

  task automatic test_sender_pause();
    send_track(NL, 1'b0);
    wait_drained();
    send_track(NL, 1'b0);
  endtask

  task automatic test_full_rate();
    wait_drained();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (2) send_track(NL, 1'b0);
  endtask

  // ---------------- result checking ----------------
  function automatic void check_word(input logic [304:0] got);
    logic [304:0] want;
    string        names[12] = '{"expected", "deviation", "expected_error", "fit_failed",
                                "intercept", "slope", "intercept_var", "slope_var",
                                "covariance", "chi_square", "hits_used", "last"};
    int           lsb[12] = '{0, 32, 64, 96, 97, 129, 161, 193, 225, 257, 297, 304};
    int           wid[12] = '{32, 32, 32, 1, 32, 32, 32, 32, 32, 40, 6, 1};
    logic [304:0] mask, e, g;
    if (fit_words.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result word %h", got);
      return;
    end
    want = fit_words.pop_front();
    for (int f = 0; f < 12; f++) begin
      mask = (305'd1 << wid[f]) - 305'd1;
      e = (want >> lsb[f]) & mask;
      g = (got >> lsb[f]) & mask;
      if (e != g) begin
        fail_count++;
        if (fail_count <= 10) $display("%s mismatch: expected %h got %h", names[f], e, g);
      end
    end
  endfunction

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word({m_axis_tlast, m_axis_tdata});

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (20000) @(posedge clk_i);
      end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycles        = 0;
    fail_count    = 0;
    st_count      = 0;
    time_mode     = 1'b0;
    allowed_dev   = 32'd65536;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    rx_hold_req   = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_TIME_MODE;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_sweep();
    test_random_tracks();
    test_output_stall();
    test_sender_pause();
    test_full_rate();
    wait_drained();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/wlf_pkg.sv
hdl/wlf_alu.sv
hdl/weighted_line_fit_outlier_reject.sv
dv/tb_weighted_line_fit_outlier_reject.sv
